### rtl/aavr_pkg.sv
// Package for the axis-angle vector rotation block.
// Holds widths, fixed-point constants, the CORDIC arctangent table and the
// shared pipeline payload types. No dependencies.
`default_nettype none

package aavr_pkg;

    localparam int COORD_W = 32;
    localparam int ANGLE_W = 16;
    localparam int MAG_W = COORD_W - 1;
    localparam int FRAC = 30;

    localparam int NORM_STAGES = 5;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES = 32;
    localparam int CORDIC_STAGES = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int COMB_STAGES = 6;

    localparam int Z_W = 36;
    localparam int XY_W = 34;

    localparam logic signed [Z_W-1:0] HALF_PI30 = 36'sd1686629713;
    localparam logic signed [Z_W-1:0] PI30 = 36'sd3373259426;
    localparam logic signed [XY_W-1:0] GAIN30 = 34'sd652032874;
    localparam logic signed [XY_W-1:0] ONE30 = 34'sd1073741824;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic [MAG_W-1:0] mag_t;
    typedef logic [2:0][MAG_W-1:0] mag3_t;
    typedef logic [2:0][COORD_W-1:0] coord3_t;

    typedef struct packed {
        coord_t vec_x;
        coord_t vec_y;
        coord_t vec_z;
        coord_t vec_w;
        angle_t theta;
        logic   zero;
    } side_t;

    typedef struct packed {
        coord_t c;
        coord_t s;
    } cs_t;

    function automatic logic signed [Z_W-1:0] atan_at(input int i);
        logic signed [Z_W-1:0] a;
        case (i)
            0: a = 36'sd843314857;
            1: a = 36'sd497837829;
            2: a = 36'sd263043837;
            3: a = 36'sd133525159;
            4: a = 36'sd67021687;
            5: a = 36'sd33543516;
            6: a = 36'sd16775851;
            7: a = 36'sd8388437;
            8: a = 36'sd4194283;
            9: a = 36'sd2097149;
            default: a = 36'sd1 <<< (30 - i);
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

### rtl/aavr_if.sv
// Word channels of the axis-angle vector rotation block.
// Depends on aavr_pkg for the payload types.
`default_nettype none

interface aavr_req_if;
    import aavr_pkg::*;
    logic   valid;
    logic   ready;
    coord_t vec_x;
    coord_t vec_y;
    coord_t vec_z;
    coord_t vec_w;
    coord_t axis_x;
    coord_t axis_y;
    coord_t axis_z;
    angle_t turn_angle;
    modport source (output valid, vec_x, vec_y, vec_z, vec_w, axis_x, axis_y, axis_z,
                    turn_angle, input ready);
    modport sink (input valid, vec_x, vec_y, vec_z, vec_w, axis_x, axis_y, axis_z,
                  turn_angle, output ready);
endinterface

interface aavr_rsp_if;
    import aavr_pkg::*;
    logic   valid;
    logic   ready;
    coord_t rot_x;
    coord_t rot_y;
    coord_t rot_z;
    coord_t rot_w;
    logic   axis_zero;
    logic   clipped;
    modport source (output valid, rot_x, rot_y, rot_z, rot_w, axis_zero, clipped,
                    input ready);
    modport sink (input valid, rot_x, rot_y, rot_z, rot_w, axis_zero, clipped,
                  output ready);
endinterface

`default_nettype wire

### rtl/axis_angle_vector_rotation.sv
// Top level of the axis-angle vector rotation block.
// Depends on aavr_pkg, aavr_if and the aavr_* pipeline modules.
//
// Rotates (vec_x, vec_y, vec_z) about (axis_x, axis_y, axis_z) by turn_angle
// with Rodrigues' formula, all in fixed point: Q16.16 coordinates, Q3.13
// angle, unit axis and sine/cosine in Q2.30. One word is accepted every
// cycle while the pipe advances. The word passes through axis scaling,
// square root (one root bit per stage, with the 32-stage CORDIC running
// alongside), division (a setup stage, then one quotient bit per stage)
// and products, rounding and saturation, the last of which is the output
// register. The whole pipe advances together whenever the output register
// is empty or being taken, so a stall on the result side holds every stage
// and drops nothing. vec_w is copied through; a zero axis returns the
// vector unchanged with axis_zero set, and clipped marks a saturated result.
`default_nettype none

module axis_angle_vector_rotation (
    input  logic        clk,
    input  logic        rst_n,
    aavr_req_if.sink    req,
    aavr_rsp_if.source  rsp
);
    import aavr_pkg::*;

    logic    adv;
    logic    out_valid;
    side_t   side_in;

    logic    norm_valid;
    side_t   norm_side;
    mag3_t   norm_ms;
    logic [2:0] norm_neg;
    logic [63:0] norm_l2;

    logic    sqrt_valid;
    side_t   sqrt_side;
    mag3_t   sqrt_ms;
    logic [2:0] sqrt_neg;
    logic [31:0] sqrt_root;

    cs_t     trig;

    logic    div_valid;
    side_t   div_side;
    cs_t     div_cs;
    coord3_t div_k;

    coord3_t rot;

    // advance the whole pipe when the output register can take a word
    assign adv = !out_valid || rsp.ready;
    assign req.ready = adv;

    always_comb
    begin
        side_in.vec_x = req.vec_x;
        side_in.vec_y = req.vec_y;
        side_in.vec_z = req.vec_z;
        side_in.vec_w = req.vec_w;
        side_in.theta = req.turn_angle;
        side_in.zero  = 1'b0;
    end

    aavr_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (req.valid),
        .side_in   (side_in),
        .axis_x    (req.axis_x),
        .axis_y    (req.axis_y),
        .axis_z    (req.axis_z),
        .valid_out (norm_valid),
        .side_out  (norm_side),
        .ms_out    (norm_ms),
        .neg_out   (norm_neg),
        .l2_out    (norm_l2)
    );

    aavr_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (norm_valid),
        .side_in   (norm_side),
        .ms_in     (norm_ms),
        .neg_in    (norm_neg),
        .l2_in     (norm_l2),
        .valid_out (sqrt_valid),
        .side_out  (sqrt_side),
        .ms_out    (sqrt_ms),
        .neg_out   (sqrt_neg),
        .root_out  (sqrt_root)
    );

    // same depth as the root, so sine and cosine line up with it
    aavr_cordic u_cordic (
        .clk    (clk),
        .en     (adv),
        .theta  (norm_side.theta),
        .cs_out (trig)
    );

    aavr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (sqrt_valid),
        .side_in   (sqrt_side),
        .cs_in     (trig),
        .ms_in     (sqrt_ms),
        .neg_in    (sqrt_neg),
        .root_in   (sqrt_root),
        .valid_out (div_valid),
        .side_out  (div_side),
        .cs_out    (div_cs),
        .k_out     (div_k)
    );

    aavr_comb u_comb (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (div_valid),
        .side_in   (div_side),
        .cs_in     (div_cs),
        .k_in      (div_k),
        .valid_out (out_valid),
        .rot_out   (rot),
        .w_out     (rsp.rot_w),
        .zero_out  (rsp.axis_zero),
        .clip_out  (rsp.clipped)
    );

    assign rsp.valid = out_valid;
    assign rsp.rot_x = rot[0];
    assign rsp.rot_y = rot[1];
    assign rsp.rot_z = rot[2];

endmodule

`default_nettype wire

### rtl/aavr_norm.sv
// Axis pre-scaling: magnitudes, leading-zero shift and squared length.
// Depends on aavr_pkg.
`default_nettype none

module aavr_norm (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  aavr_pkg::side_t      side_in,
    input  aavr_pkg::coord_t     axis_x,
    input  aavr_pkg::coord_t     axis_y,
    input  aavr_pkg::coord_t     axis_z,
    output logic                 valid_out,
    output aavr_pkg::side_t      side_out,
    output aavr_pkg::mag3_t      ms_out,
    output logic [2:0]           neg_out,
    output logic [63:0]          l2_out
);
    import aavr_pkg::*;

    logic [NORM_STAGES-1:0] valid_reg;

    coord_t a [3];
    coord_t as_v [3];
    logic   big;
    mag3_t  mag_next;
    logic [2:0] neg_next;

    side_t  s1_side_reg, s2_side_reg, s3_side_reg, s4_side_reg, s5_side_reg;
    mag3_t  s1_mag_reg, s2_mag_reg, s3_ms_reg, s4_ms_reg, s5_ms_reg;
    logic [2:0] s1_neg_reg, s2_neg_reg, s3_neg_reg, s4_neg_reg, s5_neg_reg;
    logic [4:0] s2_sh_reg;
    logic [4:0] sh_next;
    mag_t   m_max;
    logic [2*MAG_W-1:0] s4_sq_reg [3];
    logic [63:0] s5_l2_reg;
    side_t  side_z;

    always_comb
    begin
        a[0] = axis_x;
        a[1] = axis_y;
        a[2] = axis_z;
        big = (a[0] == {1'b1, {MAG_W{1'b0}}}) || (a[1] == {1'b1, {MAG_W{1'b0}}})
            || (a[2] == {1'b1, {MAG_W{1'b0}}});
        for (int i = 0; i < 3; i++)
        begin
            as_v[i] = big ? (a[i] >>> 1) : a[i];
            neg_next[i] = as_v[i][COORD_W-1];
            mag_next[i] = neg_next[i] ? MAG_W'(-as_v[i]) : as_v[i][MAG_W-1:0];
        end
        side_z = side_in;
        side_z.zero = (axis_x == '0) && (axis_y == '0) && (axis_z == '0);
    end

    // leading-zero count of the largest magnitude
    always_comb
    begin
        m_max = s1_mag_reg[0];
        if (s1_mag_reg[1] > m_max) m_max = s1_mag_reg[1];
        if (s1_mag_reg[2] > m_max) m_max = s1_mag_reg[2];
        sh_next = '0;
        for (int b = 0; b < MAG_W; b++)
        begin
            if (m_max[b]) sh_next = 5'(MAG_W - 1 - b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NORM_STAGES-2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= side_z;
            s1_mag_reg  <= mag_next;
            s1_neg_reg  <= neg_next;

            s2_side_reg <= s1_side_reg;
            s2_mag_reg  <= s1_mag_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_sh_reg   <= sh_next;

            s3_side_reg <= s2_side_reg;
            s3_neg_reg  <= s2_neg_reg;
            for (int i = 0; i < 3; i++)
                s3_ms_reg[i] <= s2_mag_reg[i] << s2_sh_reg;

            s4_side_reg <= s3_side_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_ms_reg   <= s3_ms_reg;
            for (int i = 0; i < 3; i++)
                s4_sq_reg[i] <= s3_ms_reg[i] * s3_ms_reg[i];

            s5_side_reg <= s4_side_reg;
            s5_neg_reg  <= s4_neg_reg;
            s5_ms_reg   <= s4_ms_reg;
            s5_l2_reg   <= 64'(s4_sq_reg[0]) + 64'(s4_sq_reg[1]) + 64'(s4_sq_reg[2]);
        end
    end

    assign valid_out = valid_reg[NORM_STAGES-1];
    assign side_out  = s5_side_reg;
    assign ms_out    = s5_ms_reg;
    assign neg_out   = s5_neg_reg;
    assign l2_out    = s5_l2_reg;

endmodule

`default_nettype wire

### rtl/aavr_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on aavr_pkg.
`default_nettype none

module aavr_sqrt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  aavr_pkg::side_t      side_in,
    input  aavr_pkg::mag3_t      ms_in,
    input  logic [2:0]           neg_in,
    input  logic [63:0]          l2_in,
    output logic                 valid_out,
    output aavr_pkg::side_t      side_out,
    output aavr_pkg::mag3_t      ms_out,
    output logic [2:0]           neg_out,
    output logic [31:0]          root_out
);
    import aavr_pkg::*;

    logic [SQRT_STAGES-1:0] valid_reg;
    logic [63:0] n_reg [SQRT_STAGES];
    logic [63:0] r_reg [SQRT_STAGES];
    side_t       side_reg [SQRT_STAGES];
    mag3_t       ms_reg [SQRT_STAGES];
    logic [2:0]  neg_reg [SQRT_STAGES];

    for (genvar j = 0; j < SQRT_STAGES; j++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
        logic        v_in;
        logic [63:0] n_in, r_in, t;
        side_t       sd_in;
        mag3_t       m_in;
        logic [2:0]  ng_in;
        logic        ge;

        if (j == 0)
        begin : g_first
            assign v_in  = valid_in;
            assign n_in  = l2_in;
            assign r_in  = '0;
            assign sd_in = side_in;
            assign m_in  = ms_in;
            assign ng_in = neg_in;
        end
        else
        begin : g_next
            assign v_in  = valid_reg[j-1];
            assign n_in  = n_reg[j-1];
            assign r_in  = r_reg[j-1];
            assign sd_in = side_reg[j-1];
            assign m_in  = ms_reg[j-1];
            assign ng_in = neg_reg[j-1];
        end

        assign t  = r_in + BIT;
        assign ge = (n_in >= t);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[j]    <= ge ? (n_in - t) : n_in;
                r_reg[j]    <= ge ? ((r_in >> 1) + BIT) : (r_in >> 1);
                side_reg[j] <= sd_in;
                ms_reg[j]   <= m_in;
                neg_reg[j]  <= ng_in;
            end
        end
    end

    assign valid_out = valid_reg[SQRT_STAGES-1];
    assign side_out  = side_reg[SQRT_STAGES-1];
    assign ms_out    = ms_reg[SQRT_STAGES-1];
    assign neg_out   = neg_reg[SQRT_STAGES-1];
    assign root_out  = r_reg[SQRT_STAGES-1][31:0];

endmodule

`default_nettype wire

### rtl/aavr_div.sv
// Pipelined restoring divider for the three unit-axis components.
// Depends on aavr_pkg.
`default_nettype none

module aavr_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  aavr_pkg::side_t      side_in,
    input  aavr_pkg::cs_t        cs_in,
    input  aavr_pkg::mag3_t      ms_in,
    input  logic [2:0]           neg_in,
    input  logic [31:0]          root_in,
    output logic                 valid_out,
    output aavr_pkg::side_t      side_out,
    output aavr_pkg::cs_t        cs_out,
    output aavr_pkg::coord3_t    k_out
);
    import aavr_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [63:0]  rem_reg [DIV_STAGES][3];
    logic [MAG_W-1:0] q_reg [DIV_STAGES][3];
    logic [31:0]  den_reg [DIV_STAGES];
    side_t        side_reg [DIV_STAGES];
    cs_t          cs_reg [DIV_STAGES];
    logic [2:0]   neg_reg [DIV_STAGES];

    // setup: rounded dividend (mag << 30) + root / 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[0][l] <= (64'(ms_in[l]) << FRAC) + 64'(root_in >> 1);
                q_reg[0][l]   <= '0;
            end
            den_reg[0]  <= root_in;
            side_reg[0] <= side_in;
            cs_reg[0]   <= cs_in;
            neg_reg[0]  <= neg_in;
        end
    end

    for (genvar j = 1; j < DIV_STAGES; j++)
    begin : g_stage
        localparam int SH = DIV_STAGES - 1 - j;
        logic [63:0] dsh;
        logic [2:0]  ge;

        assign dsh = 64'(den_reg[j-1]) << SH;

        always_comb
        begin
            for (int l = 0; l < 3; l++)
                ge[l] = (rem_reg[j-1][l] >= dsh);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[j][l] <= ge[l] ? (rem_reg[j-1][l] - dsh) : rem_reg[j-1][l];
                    q_reg[j][l]   <= {q_reg[j-1][l][MAG_W-2:0], ge[l]};
                end
                den_reg[j]  <= den_reg[j-1];
                side_reg[j] <= side_reg[j-1];
                cs_reg[j]   <= cs_reg[j-1];
                neg_reg[j]  <= neg_reg[j-1];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            k_out[l] = neg_reg[DIV_STAGES-1][l] ? -{1'b0, q_reg[DIV_STAGES-1][l]}
                                                 : {1'b0, q_reg[DIV_STAGES-1][l]};
        end
    end

    assign valid_out = valid_reg[DIV_STAGES-1];
    assign side_out  = side_reg[DIV_STAGES-1];
    assign cs_out    = cs_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

### rtl/aavr_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine in Q2.30.
// Depends on aavr_pkg for constants and the arctangent table.
`default_nettype none

module aavr_cordic (
    input  logic              clk,
    input  logic              en,
    input  aavr_pkg::angle_t  theta,
    output aavr_pkg::cs_t     cs_out
);
    import aavr_pkg::*;

    logic signed [XY_W-1:0] x_reg [CORDIC_STAGES];
    logic signed [XY_W-1:0] y_reg [CORDIC_STAGES];
    logic signed [Z_W-1:0]  z_reg [CORDIC_STAGES];
    logic                   flip_reg [CORDIC_STAGES];

    // fold the angle into [-pi/2, pi/2]
    logic signed [Z_W-1:0] th;
    assign th = Z_W'(theta) <<< 17;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= GAIN30;
            y_reg[0] <= '0;
            if (th > HALF_PI30)
            begin
                z_reg[0]    <= th - PI30;
                flip_reg[0] <= 1'b1;
            end
            else if (th < -HALF_PI30)
            begin
                z_reg[0]    <= th + PI30;
                flip_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0]    <= th;
                flip_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar j = 1; j <= CORDIC_STEPS; j++)
    begin : g_step
        localparam logic signed [Z_W-1:0] AT = atan_at(j - 1);
        logic signed [XY_W-1:0] xs, ys;

        assign xs = x_reg[j-1] >>> (j - 1);
        assign ys = y_reg[j-1] >>> (j - 1);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[j-1][Z_W-1])
                begin
                    x_reg[j] <= x_reg[j-1] - ys;
                    y_reg[j] <= y_reg[j-1] + xs;
                    z_reg[j] <= z_reg[j-1] - AT;
                end
                else
                begin
                    x_reg[j] <= x_reg[j-1] + ys;
                    y_reg[j] <= y_reg[j-1] - xs;
                    z_reg[j] <= z_reg[j-1] + AT;
                end
                flip_reg[j] <= flip_reg[j-1];
            end
        end
    end

    // undo the fold, clamp to [-1, 1]
    logic signed [XY_W-1:0] xf, yf, xc, yc;

    always_comb
    begin
        xf = flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
        yf = flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        xc = (xf > ONE30) ? ONE30 : ((xf < -ONE30) ? -ONE30 : xf);
        yc = (yf > ONE30) ? ONE30 : ((yf < -ONE30) ? -ONE30 : yf);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[CORDIC_STAGES-1]    <= xc;
            y_reg[CORDIC_STAGES-1]    <= yc;
            z_reg[CORDIC_STAGES-1]    <= '0;
            flip_reg[CORDIC_STAGES-1] <= 1'b0;
        end
    end

    assign cs_out.c = x_reg[CORDIC_STAGES-1][COORD_W-1:0];
    assign cs_out.s = y_reg[CORDIC_STAGES-1][COORD_W-1:0];

endmodule

`default_nettype wire

### rtl/aavr_comb.sv
// Rodrigues sum: cross and dot products, the three terms, saturation.
// The last stage is the output register. Depends on aavr_pkg.
`default_nettype none

module aavr_comb (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  aavr_pkg::side_t      side_in,
    input  aavr_pkg::cs_t        cs_in,
    input  aavr_pkg::coord3_t    k_in,
    output logic                 valid_out,
    output aavr_pkg::coord3_t    rot_out,
    output aavr_pkg::coord_t     w_out,
    output logic                 zero_out,
    output logic                 clip_out
);
    import aavr_pkg::*;

    localparam logic signed [63:0] HALF64 = 64'sd536870912;

    logic [COMB_STAGES-1:0] valid_reg;
    side_t   sd1_reg, sd2_reg, sd3_reg, sd4_reg, sd5_reg;
    coord3_t k1_reg, k2_reg, k3_reg, k4_reg;
    cs_t     cs1_reg;
    coord_t  s2_reg;

    logic signed [63:0] kv_reg [3][3];
    logic signed [63:0] vc_reg [3];
    logic signed [34:0] cr_reg [3];
    logic signed [34:0] d_reg;
    logic signed [32:0] omc_reg;
    logic signed [33:0] t1_2_reg [3], t1_3_reg [3], t1_4_reg [3], t1_5_reg [3];
    logic signed [66:0] crs_reg [3];
    logic signed [67:0] dom_reg;
    logic signed [35:0] t2_4_reg [3], t2_5_reg [3];
    logic signed [35:0] t_reg;
    logic signed [67:0] kt_reg [3];

    coord3_t rot_reg;
    coord_t  w_reg;
    logic    zero_reg, clip_reg;

    coord_t v_in [3];
    coord_t v5 [3];

    always_comb
    begin
        v_in[0] = side_in.vec_x;
        v_in[1] = side_in.vec_y;
        v_in[2] = side_in.vec_z;
        v5[0]   = sd5_reg.vec_x;
        v5[1]   = sd5_reg.vec_y;
        v5[2]   = sd5_reg.vec_z;
    end

    // stage 2 arithmetic
    logic signed [64:0] dif [3];
    logic signed [65:0] dot;
    always_comb
    begin
        dif[0] = 65'(kv_reg[1][2]) - 65'(kv_reg[2][1]);
        dif[1] = 65'(kv_reg[2][0]) - 65'(kv_reg[0][2]);
        dif[2] = 65'(kv_reg[0][1]) - 65'(kv_reg[1][0]);
        dot = 66'(kv_reg[0][0]) + 66'(kv_reg[1][1]) + 66'(kv_reg[2][2]);
    end

    // stage 6: sum and saturate
    logic signed [37:0] sum [3];
    logic signed [35:0] t3 [3];
    coord3_t rot_next;
    logic    clip_next;
    always_comb
    begin
        clip_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            t3[i]  = 36'((kt_reg[i] + 68'sd536870912) >>> FRAC);
            sum[i] = 38'(t1_5_reg[i]) + 38'(t2_5_reg[i]) + 38'(t3[i]);
            if (!sum[i][37] && (sum[i][36:31] != '0))
            begin
                rot_next[i] = {1'b0, {(COORD_W-1){1'b1}}};
                clip_next = 1'b1;
            end
            else if (sum[i][37] && (sum[i][36:31] != '1))
            begin
                rot_next[i] = {1'b1, {(COORD_W-1){1'b0}}};
                clip_next = 1'b1;
            end
            else
            begin
                rot_next[i] = sum[i][COORD_W-1:0];
            end
        end
        if (sd5_reg.zero)
        begin
            for (int i = 0; i < 3; i++)
                rot_next[i] = v5[i];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[COMB_STAGES-2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: all k*v and v*c products
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    kv_reg[i][j] <= $signed(k_in[i]) * v_in[j];
                vc_reg[i] <= v_in[i] * cs_in.c;
            end
            sd1_reg <= side_in;
            k1_reg  <= k_in;
            cs1_reg <= cs_in;

            // stage 2: cross, dot, first term
            for (int i = 0; i < 3; i++)
            begin
                cr_reg[i]   <= 35'((dif[i] + 65'sd536870912) >>> FRAC);
                t1_2_reg[i] <= 34'((vc_reg[i] + HALF64) >>> FRAC);
            end
            d_reg   <= 35'((dot + 66'sd536870912) >>> FRAC);
            omc_reg <= 33'sd1073741824 - 33'(cs1_reg.c);
            s2_reg  <= cs1_reg.s;
            sd2_reg <= sd1_reg;
            k2_reg  <= k1_reg;

            // stage 3: cross * sin, dot * (1 - cos)
            for (int i = 0; i < 3; i++)
                crs_reg[i] <= cr_reg[i] * s2_reg;
            dom_reg  <= d_reg * omc_reg;
            t1_3_reg <= t1_2_reg;
            sd3_reg  <= sd2_reg;
            k3_reg   <= k2_reg;

            // stage 4: round
            for (int i = 0; i < 3; i++)
                t2_4_reg[i] <= 36'((crs_reg[i] + 67'sd536870912) >>> FRAC);
            t_reg    <= 36'((dom_reg + 68'sd536870912) >>> FRAC);
            t1_4_reg <= t1_3_reg;
            sd4_reg  <= sd3_reg;
            k4_reg   <= k3_reg;

            // stage 5: k * t
            for (int i = 0; i < 3; i++)
                kt_reg[i] <= $signed(k4_reg[i]) * t_reg;
            t1_5_reg <= t1_4_reg;
            t2_5_reg <= t2_4_reg;
            sd5_reg  <= sd4_reg;

            // stage 6: output register
            rot_reg  <= rot_next;
            clip_reg <= clip_next;
            zero_reg <= sd5_reg.zero;
            w_reg    <= sd5_reg.vec_w;
        end
    end

    assign valid_out = valid_reg[COMB_STAGES-1];
    assign rot_out   = rot_reg;
    assign w_out     = w_reg;
    assign zero_out  = zero_reg;
    assign clip_out  = clip_reg;

endmodule

`default_nettype wire
